// ===== src/sliding_window_min_seed_select_macros.svh =====
// Assertion macros for the sliding window minimum seed selector.
// Each macro samples on clk and is switched off while rst is high.
`ifndef SLIDING_WINDOW_MIN_SEED_SELECT_MACROS_SVH
`define SLIDING_WINDOW_MIN_SEED_SELECT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SWMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define SWMS_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== src/swms_pkg.sv =====
// Shared types and constants for the sliding window minimum seed selector.
// Used by the front, queue and back modules; depends on nothing.
package swms_pkg;

  localparam int SEED_W      = 64;
  localparam int SEL_W       = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int LEN_REGS    = 4;
  // Active length field, wide enough for the largest supported window
  localparam int LEN_FIELD_W = 9;
  localparam int KIND_W      = 2;

  // Command kinds decided by the front
  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BYPASS = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [SEL_W-1:0]       shape;
    logic [LEN_FIELD_W-1:0] len;
    logic [SEED_W-1:0]      seed;
  } swms_cmd_t;

endpackage

// ===== src/swms_front.sv =====
// Front end: window length registers and item classification.
// Depends on swms_pkg; feeds commands to swms_queue.
module swms_front #(
  parameter int NUM_SHAPES = 4,
  parameter int MAX_WINDOW = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [swms_pkg::SEED_W-1:0]         in_seed,
  input  logic [swms_pkg::SEL_W-1:0]          in_shape,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output swms_pkg::swms_cmd_t                 cmd
);
  import swms_pkg::*;

  localparam int LEN_W = ($clog2(MAX_WINDOW + 1) > CFG_DATA_W) ?
                         $clog2(MAX_WINDOW + 1) : CFG_DATA_W;

  logic [LEN_W-1:0] len_reg [LEN_REGS];
  logic [LEN_W-1:0] len_raw;
  logic [LEN_W-1:0] len_act;

  assign cfg_ready = 1'b1;

  // Hold the window length registers; ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < LEN_REGS; r++) begin
        len_reg[r] <= LEN_W'(MAX_WINDOW);
      end
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) < LEN_REGS)) begin
      len_reg[cfg_index[SEL_W-1:0]] <= LEN_W'(cfg_data);
    end
  end

  // Clamp the length: zero acts as one, anything above the window saturates
  assign len_raw = len_reg[in_shape];

  always_comb begin
    if (len_raw == '0) begin
      len_act = LEN_W'(1);
    end else if (32'(len_raw) > MAX_WINDOW) begin
      len_act = LEN_W'(MAX_WINDOW);
    end else begin
      len_act = len_raw;
    end
  end

  // Classify the item
  always_comb begin
    cmd.seed  = in_seed;
    cmd.shape = in_shape;
    cmd.len   = LEN_FIELD_W'(len_act);
    if (in_mode) begin
      cmd.kind = KIND_CLEAR;
    end else if (32'(in_shape) >= NUM_SHAPES) begin
      cmd.kind = KIND_BYPASS;
    end else begin
      cmd.kind = KIND_PUSH;
    end
  end

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

endmodule

// ===== src/swms_queue.sv =====
// Two-entry command queue between the front and the back.
// Depends on swms_pkg for the command type.
module swms_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  swms_pkg::swms_cmd_t in_cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output swms_pkg::swms_cmd_t out_cmd
);
  import swms_pkg::*;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  swms_cmd_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != QUEUE_DEPTH);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Store the incoming command
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ===== src/swms_back.sv =====
// Back end: window memory, per-shape index, fill count and minimum, rescan
// sequencer and output register. Depends on swms_pkg and the assertion macros.
`include "sliding_window_min_seed_select_macros.svh"

module swms_back #(
  parameter int NUM_SHAPES = 4,
  parameter int MAX_WINDOW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  swms_pkg::swms_cmd_t         cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_reported,
  output logic [swms_pkg::SEED_W-1:0] out_seed
);
  import swms_pkg::*;

  localparam int NUM_ACTIVE = (NUM_SHAPES < (1 << SEL_W)) ? NUM_SHAPES : (1 << SEL_W);
  localparam int SHAPE_W    = (NUM_ACTIVE > 1) ? $clog2(NUM_ACTIVE) : 1;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int FILL_W     = IDX_W + 1;
  localparam int ADDR_W     = SHAPE_W + IDX_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_TAIL  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]             state;
  swms_cmd_t              cmd_q;
  logic [IDX_W-1:0]       pos_q;
  logic [IDX_W-1:0]       scan_idx;
  logic [SEED_W-1:0]      run_min;
  logic                   rd_pend;
  logic                   rd_ok;
  logic [SEED_W-1:0]      rd_data;
  logic                   res_rep;
  logic [SEED_W-1:0]      res_seed;

  logic [IDX_W-1:0]       widx    [NUM_ACTIVE];
  logic [FILL_W-1:0]      fill    [NUM_ACTIVE];
  logic [SEED_W-1:0]      cur_min [NUM_ACTIVE];
  logic [SEED_W-1:0]      mem     [MEM_DEPTH];

  logic [SHAPE_W-1:0]     sh;
  logic [LEN_FIELD_W-1:0] len_sel;
  logic [IDX_W-1:0]       widx_cur;
  logic [FILL_W-1:0]      fill_cur;
  logic [SEED_W-1:0]      min_cur;
  logic [IDX_W-1:0]       pos_start;
  logic [IDX_W-1:0]       pos_adv;
  logic [FILL_W-1:0]      pos_p1;
  logic [IDX_W-1:0]       rd_idx;
  logic                   rd_ok_next;
  logic [SEED_W-1:0]      rd_val;
  logic [SEED_W-1:0]      scan_min;
  logic                   out_free;

  // Select the shape being worked on: queue head when idle, else the held item
  assign sh        = (state == ST_IDLE) ? cmd.shape[SHAPE_W-1:0] : cmd_q.shape[SHAPE_W-1:0];
  assign len_sel   = (state == ST_IDLE) ? cmd.len : cmd_q.len;
  assign widx_cur  = widx[sh];
  assign fill_cur  = fill[sh];
  assign min_cur   = cur_min[sh];

  // Slot position: a stale index past the active length restarts at slot zero
  assign pos_start = (32'(widx_cur) >= 32'(len_sel)) ? '0 : widx_cur;
  assign pos_adv   = ((32'(pos_q) + 1) >= 32'(cmd_q.len)) ? '0 : pos_q + IDX_W'(1);
  assign pos_p1    = {1'b0, pos_q} + FILL_W'(1);

  // Slots beyond the fill count have not been written since clear and read as zero
  assign rd_idx     = (state == ST_SCAN) ? scan_idx : pos_start;
  assign rd_ok_next = ({1'b0, rd_idx} < fill_cur);
  assign rd_val     = rd_ok ? rd_data : '0;
  assign scan_min   = (rd_val < run_min) ? rd_val : run_min;

  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE);

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      mem[{sh, pos_q}] <= cmd_q.seed;
    end
    rd_data <= mem[{sh, rd_idx}];
  end

  // Sequencer and per-shape state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      for (int s = 0; s < NUM_ACTIVE; s++) begin
        widx[s]    <= '0;
        fill[s]    <= '0;
        cur_min[s] <= '1;
      end
    end else begin
      rd_ok <= rd_ok_next;
      // Raise the result when it is emitted, drop it once taken
      if ((state == ST_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            case (cmd.kind)
              KIND_PUSH: begin
                pos_q <= pos_start;
                state <= ST_CHECK;
              end
              KIND_CLEAR: begin
                for (int s = 0; s < NUM_ACTIVE; s++) begin
                  widx[s]    <= '0;
                  fill[s]    <= '0;
                  cur_min[s] <= '1;
                end
                res_rep  <= 1'b0;
                res_seed <= '0;
                state    <= ST_EMIT;
              end
              default: begin
                res_rep  <= 1'b0;
                res_seed <= cmd.seed;
                state    <= ST_EMIT;
              end
            endcase
          end
        end
        ST_CHECK: begin
          widx[sh] <= pos_adv;
          if (fill_cur < pos_p1) begin
            fill[sh] <= pos_p1;
          end
          if (rd_val == min_cur) begin
            // Overwrote the minimum: rescan the active window
            run_min  <= cmd_q.seed;
            scan_idx <= '0;
            state    <= ST_SCAN;
          end else if (cmd_q.seed < min_cur) begin
            cur_min[sh] <= cmd_q.seed;
            res_rep     <= 1'b1;
            res_seed    <= cmd_q.seed;
            state       <= ST_EMIT;
          end else begin
            res_rep  <= 1'b0;
            res_seed <= cmd_q.seed;
            state    <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          rd_pend <= 1'b1;
          if (rd_pend) begin
            run_min <= scan_min;
          end
          if ((32'(scan_idx) + 1) == 32'(cmd_q.len)) begin
            state <= ST_TAIL;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        ST_TAIL: begin
          // Fold in the last slot read and commit the new minimum
          rd_pend     <= 1'b0;
          cur_min[sh] <= scan_min;
          res_rep     <= 1'b1;
          res_seed    <= scan_min;
          state       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_reported <= res_rep;
            out_seed     <= res_seed;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SWMS_ASSERT(a_scan_in_window, (state != ST_SCAN) || (32'(scan_idx) < 32'(cmd_q.len)), "rescan index past active length")
  `SWMS_ASSERT_NEXT(a_tail_reports, state == ST_TAIL, (state == ST_EMIT) && res_rep, "rescan finished without a report")
  `SWMS_ASSERT_NEXT(a_fill_covers_pos, state == ST_CHECK, 32'(fill[sh]) > 32'(pos_q), "written slot outside fill count")
  `SWMS_ASSERT_NEXT(a_clear_result, (state == ST_IDLE) && cmd_valid && (cmd.kind == KIND_CLEAR), (state == ST_EMIT) && !res_rep && (res_seed == '0), "clear gave a wrong result")

endmodule

// ===== src/sliding_window_min_seed_select.sv =====
// Sliding window minimum seed selector, top level.
// Channels: s_axis carries one item per seed push or clear; m_axis returns one
// result item per input item, in order. cfg writes a window length register
// (index 0..3 for shapes 0..3, 6-bit value); cfg_ready is always high and a
// write must only be made while no item is in flight.
// Timing: an accepted item enters a two-entry queue in the same cycle. The
// back end then goes from idle straight to emit for a clear or an unknown
// shape, through a check state for a push, and through check, a rescan of
// every slot of the active window and a tail state for a push that
// overwrites the current minimum: the rescan reads one slot per cycle through
// the single read port of the window memory. The back end takes one item at a
// time and accepts no new item before the last result is emitted.
// Reset: lengths return to MAX_WINDOW, windows read as zero, indices clear and
// minima become all ones; no clearing pass is needed.
// Stall: a result waits in the output register while m_axis_tready is low; the
// back end finishes at most one more item, then the queue fills and
// s_axis_tready drops.
module sliding_window_min_seed_select #(
  parameter int NUM_SHAPES = 4,
  parameter int MAX_WINDOW = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swms_pkg::SEED_W-1:0]         s_axis_tdata,  // [63:0] seed_value
  input  logic [swms_pkg::SEL_W:0]            s_axis_tuser,  // [0] mode, [2:1] shape_sel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swms_pkg::SEED_W-1:0]         m_axis_tdata,  // [63:0] out_seed
  output logic                                m_axis_tuser,  // [0] reported
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import swms_pkg::*;

  logic      front_valid;
  logic      front_ready;
  swms_cmd_t front_cmd;
  logic      head_valid;
  logic      head_ready;
  swms_cmd_t head_cmd;

  swms_front #(
    .NUM_SHAPES (NUM_SHAPES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser[0]),
    .in_seed   (s_axis_tdata),
    .in_shape  (s_axis_tuser[SEL_W:1]),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  swms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (head_valid),
    .out_ready (head_ready),
    .out_cmd   (head_cmd)
  );

  swms_back #(
    .NUM_SHAPES (NUM_SHAPES),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd_ready    (head_ready),
    .cmd          (head_cmd),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_reported (m_axis_tuser),
    .out_seed     (m_axis_tdata)
  );

endmodule
